>>> design/process_slot_scheduler_top_macros.svh
// Assertion macros shared by the process slot scheduler RTL.
`ifndef PROCESS_SLOT_SCHEDULER_TOP_MACROS_SVH
`define PROCESS_SLOT_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define PSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

>>> design/pss_pkg.sv
// Types and constants of the process slot scheduler.
package pss_pkg;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_ZOMBIE   = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_FORK   = 2'd1,
    REQ_SIGNAL = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_NO_CUR    = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    slot_state_t  state;
    logic [15:0]  pid;
    logic [7:0]   sig;
    logic [31:0]  runtime;
  } slot_entry_t;

  localparam logic [7:0] SIG_INT  = 8'd2;
  localparam logic [7:0] SIG_KILL = 8'd9;
  localparam logic [7:0] SIG_SEGV = 8'd11;
  localparam logic [1:0] RING_USER = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 2'd1;

endpackage

>>> design/pss_slot_table.sv
// Slot table: one-read one-write memory with per-entry valid bits.
module pss_slot_table import pss_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int IDX_W     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output slot_entry_t       rd_entry,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  slot_entry_t       wr_data
);

  slot_entry_t             mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    valid_r;
  slot_entry_t             rd_data_r;
  logic                    vbit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vbit_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vbit_r <= valid_r[rd_addr];
      end
    end
  end

  // never-written entries read as an unused, cleared slot
  assign rd_entry = vbit_r ? rd_data_r : '0;

endmodule

>>> design/process_slot_scheduler_top.sv
// Top level of the process slot scheduler.
// Every request yields one result item. A create, a signal, a fork with a
// current task, or a tick with preemption armed and ring 3, walks the slot
// table one entry per cycle through the table's single read port; a fork or
// an armed tick with a current task first reads the current slot (and a tick
// charges it). An unarmed tick, or a fork with no current task, goes straight
// to apply without a scan. A new item is taken while the previous result
// waits in the output register. Slot storage needs no clearing pass after
// reset. Configuration registers:
// policy_mode (0 round-robin, 1 least runtime) and preempt_enable.
`include "process_slot_scheduler_top_macros.svh"

module process_slot_scheduler_top import pss_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  // requests
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,  // target_pid[15:0], signal_num[23:16],
                                          // caller_ring[25:24], zero pad
  input  logic [1:0]           in_tuser,  // req_type[1:0]
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [79:0]          out_tdata  // status[1:0], new_pid[17:2], switched[18],
                                          // current_slot[23:19], has_current[24],
                                          // current_pid[40:25], runnable_total[45:41],
                                          // tick_total[77:46], zero pad
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(NUM_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDCUR  = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_APPLY  = 5'b10000
  } fsm_t;

  fsm_t              state_r, state_nxt;

  logic              policy_r, preempt_r;
  req_t              req_r;
  logic [15:0]       pid_r;
  logic [7:0]        sig_r;
  logic              armed_r;

  logic [IDX_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic              cur_vld_r, cur_vld_nxt;
  logic [15:0]       cur_pid_r, cur_pid_nxt;
  logic [31:0]       cur_rt_r;
  logic [15:0]       next_id_r, next_id_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [IDX_W-1:0]  start_r;
  logic [CNT_W-1:0]  n_r;
  logic              scan_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [15:0]       hit_pid_r;
  logic [31:0]       hit_rt_r;

  logic              out_tvalid_r;
  logic [79:0]       out_tdata_r;

  // table port signals
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  slot_entry_t       rd_entry;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_entry_t       wr_data;

  logic              in_acc;
  logic              out_free;
  req_t              in_req;
  logic              in_armed;
  logic [CNT_W-1:0]  cur_inc;
  logic [IDX_W-1:0]  rr_start;
  logic              scan_issue;
  logic              scan_end;
  logic [CNT_W-1:0]  addr_sum;
  logic [CNT_W-1:0]  addr_wrap;
  logic [IDX_W-1:0]  scan_addr;
  logic              take;
  logic              term;
  status_t           status_nxt;
  logic [15:0]       new_pid_nxt;
  logic              switched_nxt;
  logic [31:0]       cur_slot_w;
  logic [31:0]       count_w;

  pss_slot_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign in_req   = req_t'(in_tuser[1:0]);
  assign in_armed = preempt_r && (in_tdata[25:24] == RING_USER);

  // round-robin starts after current, wrapping
  assign cur_inc  = {1'b0, cur_idx_r} + CNT_W'(1);
  assign rr_start = (!cur_vld_r || cur_inc == SLOTS_C) ? '0 : cur_inc[IDX_W-1:0];

  assign scan_issue = (state_r == S_SCAN) && (n_r != SLOTS_C);
  assign scan_end   = (state_r == S_SCAN) && (n_r == SLOTS_C) && !scan_vld_r;
  assign addr_sum   = {1'b0, start_r} + n_r;
  assign addr_wrap  = (addr_sum >= SLOTS_C) ? (addr_sum - SLOTS_C) : addr_sum;
  assign scan_addr  = addr_wrap[IDX_W-1:0];

  assign rd_en   = scan_issue || (state_r == S_RDCUR);
  assign rd_addr = (state_r == S_RDCUR) ? cur_idx_r : scan_addr;

  assign term = (sig_r == SIG_KILL) || (sig_r == SIG_SEGV) || (sig_r == SIG_INT);

  // scan match for the request in progress
  always_comb begin
    take = 1'b0;
    case (req_r) inside
      REQ_CREATE, REQ_FORK: take = !found_r && (rd_entry.state == ST_UNUSED);
      REQ_SIGNAL: take = !found_r && (rd_entry.state == ST_RUNNABLE)
                         && (rd_entry.pid == pid_r);
      default: begin
        if (policy_r) begin
          take = (rd_entry.state == ST_RUNNABLE)
                 && (!found_r || (rd_entry.runtime < hit_rt_r));
        end else begin
          take = !found_r && (rd_entry.state == ST_RUNNABLE);
        end
      end
    endcase
  end

  // table writes: runtime charge on an armed tick, slot update at apply
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = rd_entry;
    if (state_r == S_RDWAIT) begin
      wr_addr = cur_idx_r;
      wr_en   = (req_r == REQ_TICK);
      if (rd_entry.runtime != 32'hFFFF_FFFF) begin
        wr_data.runtime = rd_entry.runtime + 32'd1;
      end
    end else if (state_r == S_APPLY) begin
      wr_en = out_free && found_r && (req_r != REQ_TICK);
      if (req_r == REQ_SIGNAL) begin
        wr_data.state   = term ? ST_ZOMBIE : ST_RUNNABLE;
        wr_data.pid     = hit_pid_r;
        wr_data.sig     = sig_r;
        wr_data.runtime = hit_rt_r;
      end else begin
        wr_data.state   = ST_RUNNABLE;
        wr_data.pid     = next_id_r;
        wr_data.sig     = '0;
        wr_data.runtime = (req_r == REQ_FORK) ? cur_rt_r : '0;
      end
    end
  end

  // result of the request, applied in S_APPLY
  always_comb begin
    status_nxt   = STAT_OK;
    new_pid_nxt  = '0;
    switched_nxt = 1'b0;
    cur_idx_nxt  = cur_idx_r;
    cur_vld_nxt  = cur_vld_r;
    cur_pid_nxt  = cur_pid_r;
    next_id_nxt  = next_id_r;
    tick_nxt     = tick_r;
    count_nxt    = count_r;
    case (req_r) inside
      REQ_CREATE, REQ_FORK: begin
        if ((req_r == REQ_FORK) && !cur_vld_r) begin
          status_nxt = STAT_NO_CUR;
        end else if (!found_r) begin
          status_nxt = STAT_NO_SLOT;
        end else begin
          new_pid_nxt = next_id_r;
          next_id_nxt = next_id_r + 16'd1;
          count_nxt   = count_r + CNT_W'(1);
          if (!cur_vld_r) begin
            cur_idx_nxt = hit_idx_r;
            cur_vld_nxt = 1'b1;
            cur_pid_nxt = next_id_r;
          end
        end
      end
      REQ_SIGNAL: begin
        if (!found_r) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          if (term) begin
            count_nxt = count_r - CNT_W'(1);
          end
          if (cur_vld_r && (hit_idx_r == cur_idx_r)) begin
            cur_vld_nxt = 1'b0;
          end
        end
      end
      default: begin
        tick_nxt = tick_r + 32'd1;
        if (armed_r && found_r) begin
          switched_nxt = 1'b1;
          cur_idx_nxt  = hit_idx_r;
          cur_vld_nxt  = 1'b1;
          cur_pid_nxt  = hit_pid_r;
        end
      end
    endcase
  end

  assign cur_slot_w = cur_vld_nxt ? 32'(cur_idx_nxt) : 32'(NUM_SLOTS);
  assign count_w    = 32'(count_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req) inside
            REQ_CREATE, REQ_SIGNAL: state_nxt = S_SCAN;
            REQ_FORK:               state_nxt = cur_vld_r ? S_RDCUR : S_APPLY;
            default: begin
              if (!in_armed) begin
                state_nxt = S_APPLY;
              end else begin
                state_nxt = cur_vld_r ? S_RDCUR : S_SCAN;
              end
            end
          endcase
        end
      end
      S_RDCUR:  state_nxt = S_RDWAIT;
      S_RDWAIT: state_nxt = S_SCAN;
      S_SCAN:   state_nxt = scan_end ? S_APPLY : S_SCAN;
      S_APPLY:  state_nxt = out_free ? S_IDLE : S_APPLY;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      policy_r     <= 1'b0;
      preempt_r    <= 1'b0;
      cur_vld_r    <= 1'b0;
      next_id_r    <= 16'd1;
      tick_r       <= '0;
      count_r      <= '0;
      scan_vld_r   <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= scan_issue;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:  policy_r  <= cfg_wdata;
          CFG_PREEMPT: preempt_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc) begin
        found_r <= 1'b0;
      end else if ((state_r == S_SCAN) && scan_vld_r && take) begin
        found_r <= 1'b1;
      end

      if ((state_r == S_APPLY) && out_free) begin
        cur_vld_r <= cur_vld_nxt;
        next_id_r <= next_id_nxt;
        tick_r    <= tick_nxt;
        count_r   <= count_nxt;
      end

      if ((state_r == S_APPLY) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_req;
      pid_r   <= in_tdata[15:0];
      sig_r   <= in_tdata[23:16];
      armed_r <= in_armed;
      n_r     <= '0;
      start_r <= ((in_req == REQ_TICK) && !policy_r) ? rr_start : '0;
    end else if (scan_issue) begin
      n_r <= n_r + CNT_W'(1);
    end

    if (scan_issue) begin
      rd_idx_r <= scan_addr;
    end

    if ((state_r == S_RDWAIT) && (req_r == REQ_FORK)) begin
      cur_rt_r <= rd_entry.runtime;
    end

    if ((state_r == S_SCAN) && scan_vld_r && take) begin
      hit_idx_r <= rd_idx_r;
      hit_pid_r <= rd_entry.pid;
      hit_rt_r  <= rd_entry.runtime;
    end

    if ((state_r == S_APPLY) && out_free) begin
      cur_idx_r   <= cur_idx_nxt;
      cur_pid_r   <= cur_pid_nxt;
      out_tdata_r <= {2'b00,
                      tick_nxt,
                      count_w[4:0],
                      cur_vld_nxt ? cur_pid_nxt : 16'd0,
                      cur_vld_nxt,
                      cur_slot_w[4:0],
                      switched_nxt,
                      new_pid_nxt,
                      status_nxt};
    end
  end

  // a current task is always runnable, so it is counted
  `PSS_ASSERT_SAME(a_cur_counted, clk, rst_n, cur_vld_r, count_r != '0)
  `PSS_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_r <= SLOTS_C)
  // no table write while the scan reads it
  `PSS_ASSERT_SAME(a_no_wr_in_scan, clk, rst_n, state_r == S_SCAN, !wr_en)
  `PSS_ASSERT_NEXT(a_apply_gives_item, clk, rst_n,
                   (state_r == S_APPLY) && out_free, out_tvalid_r && (state_r == S_IDLE))

endmodule
